/* rtl/bcm_pkg.sv */
// Shared types, constants and codes of the binary code modulation LED driver.
package bcm_pkg;

  localparam int CHANNELS_DEF   = 32;
  localparam int PLANES_DEF     = 14;
  localparam int INPUT_BITS_DEF = 16;

  // input operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_COMMIT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_BASE_STEP   = 2'd0;
  localparam logic [1:0] REG_TRANSFER    = 2'd1;
  localparam logic [1:0] REG_RESET_LEN   = 2'd2;
  localparam logic [1:0] REG_CORRECTION  = 2'd3;

  localparam logic [2:0] BASE_STEP_RST   = 3'd4;
  localparam logic [9:0] TRANSFER_RST    = 10'd120;
  localparam logic [9:0] RESET_LEN_RST   = 10'd40;
  localparam logic [3:0] CORRECTION_RST  = 4'd2;

  localparam logic [15:0] RELOAD_MAX = 16'hffff;
  localparam logic [9:0]  DATA_COMPARE = 10'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  channel;
    logic [15:0] brightness;
  } req_t;

  typedef struct packed {
    logic        data_phase;
    logic [31:0] plane_data;
    logic [3:0]  plane_index;
    logic [15:0] reload_value;
    logic [9:0]  compare_value;
  } rsp_t;

  // command kinds held in the queue
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  channel;
    logic [15:0] brightness;
  } cmd_t;

  typedef struct packed {
    logic [2:0] base_step;
    logic [9:0] transfer_allowance;
    logic [9:0] reset_length;
    logic [3:0] period_correction;
  } cfg_t;

endpackage

/* rtl/bcm_queue.sv */
// Two-entry command queue between the front and back parts.
module bcm_queue
  import bcm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  cmd_t            mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/bcm_front.sv */
// Front part: takes request items, drops the ones with no effect, queues the rest.
module bcm_front
  import bcm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  req_t req,
  input  logic req_valid,
  output logic req_ready,
  input  logic q_full,
  output logic push,
  output cmd_t push_cmd
);

  logic keep;

  assign req_ready = !q_full;

  always_comb begin
    keep              = 1'b0;
    push_cmd.kind     = CMD_WRITE;
    push_cmd.channel  = req.channel;
    push_cmd.brightness = req.brightness;
    case (req.operation)
      OP_WRITE: begin
        // writes beyond the channel count are ignored
        keep          = ({1'b0, req.channel} < 6'(CHANNELS));
        push_cmd.kind = CMD_WRITE;
      end
      OP_COMMIT: begin
        keep          = 1'b1;
        push_cmd.kind = CMD_COMMIT;
      end
      OP_TICK: begin
        keep          = 1'b1;
        push_cmd.kind = CMD_TICK;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = req_valid && req_ready && keep;

endmodule

/* rtl/bcm_back.sv */
// Back part: brightness stores, plane selection and timer value generation.
module bcm_back
  import bcm_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int PLANES     = PLANES_DEF,
  parameter int INPUT_BITS = INPUT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_empty,
  input  cmd_t head,
  output logic pop,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_ready
);

  logic [INPUT_BITS-1:0] staging [CHANNELS];
  logic [PLANES-1:0]     display [CHANNELS];
  logic [PLANES-1:0]     disp_conv [CHANNELS];
  logic [3:0]            bit_index;
  logic                  phase_flag;
  logic [31:0]           plane;
  logic [18:0]           shifted;
  logic [18:0]           reload_sum;
  logic [15:0]           reload_sat;
  logic [4:0]            index_inc;
  logic                  out_free;

  assign out_free = !rsp_valid || rsp_ready;
  assign pop = !q_empty && ((head.kind != CMD_TICK) || out_free);

  genvar j;
  generate
    for (j = 0; j < CHANNELS; j++) begin : g_chan
      logic [15:0] disp_wide;
      if (INPUT_BITS >= PLANES) begin : g_narrow
        assign disp_conv[j] = staging[j][INPUT_BITS-1 -: PLANES];
      end else begin : g_wide
        assign disp_conv[j] = {staging[j], {(PLANES-INPUT_BITS){1'b0}}};
      end
      assign disp_wide = 16'(display[j]);
      assign plane[j]  = disp_wide[bit_index];

      always_ff @(posedge clk) begin
        if (rst) begin
          staging[j] <= '0;
          display[j] <= '0;
        end else if (pop) begin
          if (head.kind == CMD_WRITE && head.channel == 5'(j)) begin
            staging[j] <= head.brightness[INPUT_BITS-1:0];
          end
          if (head.kind == CMD_COMMIT) begin
            display[j] <= disp_conv[j];
          end
        end
      end
    end
    if (CHANNELS < 32) begin : g_pad
      assign plane[31:CHANNELS] = '0;
    end
  endgenerate

  assign shifted    = 19'(cfg.base_step) << bit_index;
  assign reload_sum = 19'(cfg.transfer_allowance) + 19'(cfg.period_correction) + shifted;
  assign reload_sat = (|reload_sum[18:16]) ? RELOAD_MAX : reload_sum[15:0];
  assign index_inc  = {1'b0, bit_index} + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index  <= '0;
      phase_flag <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (pop && head.kind == CMD_TICK) begin
        rsp_valid  <= 1'b1;
        phase_flag <= !phase_flag;
        if (!phase_flag) begin
          bit_index <= (index_inc >= 5'(PLANES)) ? 4'd0 : index_inc[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_TICK) begin
      rsp.plane_index <= bit_index;
      if (!phase_flag) begin
        // entering the data phase: emit the plane, timer holds the reset length
        rsp.data_phase    <= 1'b1;
        rsp.plane_data    <= plane;
        rsp.reload_value  <= 16'(cfg.reset_length);
        rsp.compare_value <= DATA_COMPARE;
      end else begin
        rsp.data_phase    <= 1'b0;
        rsp.plane_data    <= '0;
        rsp.reload_value  <= reload_sat;
        rsp.compare_value <= cfg.transfer_allowance;
      end
    end
  end

endmodule

/* rtl/binary_code_modulation_led_driver.sv */
// Top level of the binary code modulation LED driver.
//
// Request channel (req_valid/req_ready/req): write items store a brightness for
// one channel in the staging store, commit items copy staging into the display
// store (top PLANES bits), tick items toggle between data and reset phase.
// Response channel (rsp_valid/rsp_ready/rsp): one item per tick; writes,
// commits and unknown operations give none.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// the user is to write it only while the block is idle; the block does not enforce it.
// A tick's response passes through the two-entry queue and then the output register.
// Throughput: one item per cycle while the response side keeps up; the back part
// carries out every item, commit included, as it pops it from the queue.
// A stalled response holds the output register; ticks then wait in the queue
// and requests stall once it is full, while writes and commits ahead keep going.
// Reset clears both stores, bit index and phase, and restores register defaults.
module binary_code_modulation_led_driver
  import bcm_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int PLANES     = PLANES_DEF,
  parameter int INPUT_BITS = INPUT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_step          <= BASE_STEP_RST;
      cfg.transfer_allowance <= TRANSFER_RST;
      cfg.reset_length       <= RESET_LEN_RST;
      cfg.period_correction  <= CORRECTION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_STEP:   cfg.base_step          <= cfg_data[2:0];
        REG_TRANSFER:    cfg.transfer_allowance <= cfg_data;
        REG_RESET_LEN:   cfg.reset_length       <= cfg_data;
        REG_CORRECTION:  cfg.period_correction  <= cfg_data[3:0];
        default:         cfg <= cfg;
      endcase
    end
  end

  bcm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  bcm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  bcm_back #(
    .CHANNELS   (CHANNELS),
    .PLANES     (PLANES),
    .INPUT_BITS (INPUT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule

/* sim/tb_binary_code_modulation_led_driver.sv */
// Self-checking testbench for the binary code modulation LED driver.
module tb_binary_code_modulation_led_driver;
  import bcm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SHIFT_DOWN   = INPUT_BITS_DEF - PLANES_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 30;
  localparam int RUN_LIMIT    = 2000000;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  // model of the block
  logic [15:0]           staging_copy [CHANNELS_DEF];
  logic [PLANES_DEF-1:0] display_copy [CHANNELS_DEF];
  logic [3:0]            plane_cursor;
  logic                  in_data_phase;
  cfg_t                  tuning;
  rsp_t                  expected_frames [$];

  int items_sent, ticks_sent, frames_checked, settings_used, mismatches;
  int burst_left;
  bit gaps_on;

  // receiver side
  rx_mode_e    rx_mode = RX_STEADY;
  int          hold_asked = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [15:0] rx_pattern = 16'b1011_0110_1110_0101;

  binary_code_modulation_led_driver dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void predict_frame(req_t item);
    rsp_t        frame;
    int unsigned period;
    frame = '0;
    case (item.operation)
      OP_WRITE: staging_copy[item.channel] = item.brightness;
      OP_COMMIT: begin
        for (int j = 0; j < CHANNELS_DEF; j++)
          display_copy[j] = PLANES_DEF'(staging_copy[j] >> SHIFT_DOWN);
      end
      OP_TICK: begin
        in_data_phase = ~in_data_phase;
        frame.plane_index = plane_cursor;
        if (in_data_phase) begin
          for (int j = 0; j < CHANNELS_DEF; j++)
            frame.plane_data[j] = display_copy[j][plane_cursor];
          frame.data_phase    = 1'b1;
          frame.reload_value  = 16'(tuning.reset_length);
          frame.compare_value = DATA_COMPARE;
          plane_cursor = (plane_cursor == 4'(PLANES_DEF - 1)) ? 4'd0 : plane_cursor + 4'd1;
        end else begin
          // next data period: its base-step part doubles with each plane
          period = int'(tuning.transfer_allowance) + int'(tuning.period_correction)
                 + (int'(tuning.base_step) << plane_cursor);
          frame.reload_value  = (period > 32'(RELOAD_MAX)) ? RELOAD_MAX : 16'(period);
          frame.compare_value = tuning.transfer_allowance;
        end
        expected_frames.push_back(frame);
        ticks_sent++;
      end
      default: ;
    endcase
  endfunction

  function automatic req_t make_item(logic [1:0] op, int unsigned ch, int unsigned level);
    req_t item;
    item.operation  = op;
    item.channel    = 5'(ch);
    item.brightness = 16'(level);
    return item;
  endfunction

  function automatic req_t random_item();
    req_t        item;
    int unsigned pick;
    pick = $urandom_range(99);
    item.channel = 5'($urandom);
    if ($urandom_range(3) == 0)
      item.brightness = $urandom_range(1) ? 16'hffff : 16'h0000;
    else
      item.brightness = 16'($urandom);
    if (pick < 45)      item.operation = OP_WRITE;
    else if (pick < 55) item.operation = OP_COMMIT;
    else if (pick < 95) item.operation = OP_TICK;
    else                item.operation = OP_UNUSED;
    return item;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  // leaves req_valid high; caller sends again or lowers it in the same step
  task automatic send_item(req_t item);
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_frame(item);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_paced(req_t item);
    send_item(item);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      if (gaps_on) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(7, 1)) @(negedge clk);
      end
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE_STEP:   tuning.base_step          = value[2:0];
      REG_TRANSFER:    tuning.transfer_allowance = value;
      REG_RESET_LEN:   tuning.reset_length       = value;
      REG_CORRECTION:  tuning.period_correction  = value[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // narrow registers get junk in the unused upper data bits
  task automatic apply_settings(input int unsigned base, ta, rl, pc);
    logic [9:0] junk;
    junk = 10'($urandom);
    write_reg(REG_BASE_STEP, {junk[9:3], 3'(base)});
    write_reg(REG_TRANSFER, 10'(ta));
    write_reg(REG_RESET_LEN, 10'(rl));
    junk = 10'($urandom);
    write_reg(REG_CORRECTION, {junk[9:4], 4'(pc)});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic set_rx_mode(rx_mode_e m);
    @(posedge clk);
    rx_mode = m;
    @(negedge clk);
  endtask

  task automatic test_directed_basics();
    send_item(make_item(OP_WRITE, 0, 16'hffff));
    send_item(make_item(OP_WRITE, 31, 16'hffff));
    send_item(make_item(OP_WRITE, 1, 16'h0003));   // below the kept bits
    send_item(make_item(OP_WRITE, 2, 16'h8000));
    send_item(make_item(OP_WRITE, 3, 16'h0004));
    send_item(make_item(OP_WRITE, 30, 16'haaaa));
    send_item(make_item(OP_UNUSED, 5, 16'hffff));  // must be dropped
    send_item(make_item(OP_TICK, 0, 0));           // plane before commit: blank
    send_item(make_item(OP_TICK, 31, 16'hffff));
    send_item(make_item(OP_COMMIT, 0, 0));
    send_item(make_item(OP_WRITE, 4, 16'hffff));   // staged only, not shown
    for (int k = 0; k < 14; k++)
      send_item(make_item(OP_TICK, 0, 0));
    settle();
  endtask

  task automatic test_register_extremes();
    int unsigned base_set [4] = '{1, 7, 5, 3};
    int unsigned ta_set [4]   = '{0, 1023, 1023, 512};
    int unsigned rl_set [4]   = '{1, 1023, 1, 600};
    int unsigned pc_set [4]   = '{0, 15, 0, 9};
    for (int s = 0; s < 4; s++) begin
      apply_settings(base_set[s], ta_set[s], rl_set[s], pc_set[s]);
      // 28 ticks: every plane in both phases
      for (int k = 0; k < 36; k++) begin
        if (k % 9 == 4)
          send_item(make_item(OP_WRITE, $urandom, $urandom));
        else if (k % 9 == 7)
          send_item(make_item(OP_COMMIT, 0, 0));
        else
          send_item(make_item(OP_TICK, 0, 0));
      end
      settle();
    end
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 5; round++) begin
      apply_settings($urandom_range(7, 1), $urandom_range(1023), $urandom_range(1023, 1),
                     $urandom_range(15));
      set_rx_mode(rx_mode_e'(round % 3));
      gaps_on = (round >= 1 && round <= 3);
      burst_left = 0;
      for (int k = 0; k < 180; k++)
        send_paced(random_item());
      settle();
    end
  endtask

  task automatic test_output_holdoff();
    req_t item;
    set_rx_mode(RX_STEADY);
    @(posedge clk);
    hold_asked++;
    @(negedge clk);
    // back to back while results are refused: queue fills, input stalls
    for (int k = 0; k < 40; k++) begin
      if (k % 10 == 5)
        item = make_item(OP_WRITE, $urandom, $urandom);
      else if (k == 20)
        item = make_item(OP_COMMIT, 0, 0);
      else
        item = make_item(OP_TICK, 0, 0);
      send_item(item);
    end
    settle();
  endtask

  always @(negedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: rsp_ready <= 1'b1;
        RX_RANDOM: rsp_ready <= ($urandom_range(99) < 60);
        default:   rsp_ready <= rx_pattern[0];
      endcase
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result with none pending, plane_data", rsp.plane_data, '0);
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (rsp.data_phase != want.data_phase)
          report_mismatch("data_phase", 32'(rsp.data_phase), 32'(want.data_phase));
        if (rsp.plane_data != want.plane_data)
          report_mismatch("plane_data", rsp.plane_data, want.plane_data);
        if (rsp.plane_index != want.plane_index)
          report_mismatch("plane_index", 32'(rsp.plane_index), 32'(want.plane_index));
        if (rsp.reload_value != want.reload_value)
          report_mismatch("reload_value", 32'(rsp.reload_value), 32'(want.reload_value));
        if (rsp.compare_value != want.compare_value)
          report_mismatch("compare_value", 32'(rsp.compare_value),
                          32'(want.compare_value));
      end
    end
  end

  initial begin
    for (int j = 0; j < CHANNELS_DEF; j++) begin
      staging_copy[j] = '0;
      display_copy[j] = '0;
    end
    plane_cursor  = '0;
    in_data_phase = 1'b0;
    tuning = '{base_step: BASE_STEP_RST, transfer_allowance: TRANSFER_RST,
               reset_length: RESET_LEN_RST, period_correction: CORRECTION_RST};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_basics();
    test_register_extremes();
    test_random_traffic();
    test_output_holdoff();
    $display("covered %0d items (%0d ticks) over %0d register settings", items_sent,
             ticks_sent, settings_used);
    $display("checked %0d phase results, %0d mismatches", frames_checked, mismatches);
    if (mismatches == 0 && expected_frames.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("timeout with %0d results outstanding", expected_frames.size());
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/bcm_pkg.sv
rtl/bcm_queue.sv
rtl/bcm_front.sv
rtl/bcm_back.sv
rtl/binary_code_modulation_led_driver.sv
sim/tb_binary_code_modulation_led_driver.sv
